[src/bmvc_pkg.sv]
// ----------------------------------------------------------------------------
// bmvc_pkg
// shared types and constants for the bipartite minimum vertex cover block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmvc_pkg;

  localparam int LEFT_MAX_DEF  = 16;
  localparam int RIGHT_MAX_DEF = 16;
  localparam int MAX_RESULTS   = 17;
  localparam int VERTEX_W      = 4;
  localparam int COUNT_W       = 5;
  localparam int CFG_RESET     = 16;

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_LEFT    = 2'd1,
    KIND_RIGHT   = 2'd2
  } item_kind_t;

  localparam logic REG_LEFT_COUNT  = 1'b0;
  localparam logic REG_RIGHT_COUNT = 1'b1;

  typedef struct packed {
    logic load;
    logic match_init;
    logic aug_init;
    logic aug_step;
    logic aug_next;
    logic path_step;
    logic reach_init;
    logic reach_step;
    logic out_init;
    logic emit_sum;
    logic emit_list;
  } cmd_t;

  typedef struct packed {
    logic more_starts;
    logic pend_empty;
    logic found_free;
    logic path_end;
    logic cover_empty;
    logic list_done;
  } status_t;

endpackage

`default_nettype wire

[src/bipartite_min_vertex_cover.sv]
// ----------------------------------------------------------------------------
// bipartite_min_vertex_cover
// minimum vertex cover of a bipartite graph by maximum matching
// ----------------------------------------------------------------------------
// An edge transaction is taken when start is high and busy is low. The
// transaction with last_edge high loads its edge and then holds busy while the
// sequencer runs: for each left vertex in use a setup step, a step for each
// left vertex popped from the augmenting search, then either a closing step
// when the search runs dry or a step for each left vertex on the augmenting
// path; then a step to close the matching, one to seed the residual search,
// one for each left vertex reached in it and one to latch the cover; then one
// result per cycle: the summary, the left cover vertices and the right cover
// vertices, the last one flagged by last_result. Results come on a one-cycle
// strobe, result_valid, and cannot be held off. Configuration writes are always
// taken and belong in idle time only.
`timescale 1ns / 1ps
`default_nettype none

module bipartite_min_vertex_cover
  import bmvc_pkg::*;
#(
  parameter int LEFT_MAX  = LEFT_MAX_DEF,
  parameter int RIGHT_MAX = RIGHT_MAX_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [VERTEX_W-1:0] left_vertex,
  input  wire logic [VERTEX_W-1:0] right_vertex,
  input  wire logic                edge_present,
  input  wire logic                last_edge,
  output logic                     result_valid,
  output logic [1:0]               item_kind,
  output logic [VERTEX_W-1:0]      vertex_index,
  output logic [COUNT_W-1:0]       left_cover_size,
  output logic [COUNT_W-1:0]       right_cover_size,
  output logic                     last_result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [COUNT_W-1:0]  cfg_data
);

  cmd_t       cmd;
  status_t    status;
  item_kind_t kind;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign item_kind = kind;

  bmvc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .last_edge    (last_edge),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  bmvc_datapath #(
    .LEFT_MAX  (LEFT_MAX),
    .RIGHT_MAX (RIGHT_MAX)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .left_vertex      (left_vertex),
    .right_vertex     (right_vertex),
    .edge_present     (edge_present),
    .item_kind        (kind),
    .vertex_index     (vertex_index),
    .left_cover_size  (left_cover_size),
    .right_cover_size (right_cover_size),
    .last_result      (last_result)
  );

  a_strobe_busy : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result strobe outside a run");

  a_last_ends_run : assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |=> !busy) else $error("run continues after last result");

  a_edge_only_idle : assert property (@(posedge clk) disable iff (rst)
    accept && !last_edge |=> !busy) else $error("plain edge transaction started a run");

  a_kind_code : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_kind != 2'd3) else $error("bad result kind");

endmodule

`default_nettype wire

[src/bmvc_datapath.sv]
// ----------------------------------------------------------------------------
// bmvc_datapath
// adjacency store, matching, reachability sets and result formatting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmvc_datapath
  import bmvc_pkg::*;
#(
  parameter int LEFT_MAX  = LEFT_MAX_DEF,
  parameter int RIGHT_MAX = RIGHT_MAX_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output status_t                  status,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_index,
  input  wire logic [COUNT_W-1:0]  cfg_data,
  input  wire logic [VERTEX_W-1:0] left_vertex,
  input  wire logic [VERTEX_W-1:0] right_vertex,
  input  wire logic                edge_present,
  output item_kind_t               item_kind,
  output logic [VERTEX_W-1:0]      vertex_index,
  output logic [COUNT_W-1:0]       left_cover_size,
  output logic [COUNT_W-1:0]       right_cover_size,
  output logic                     last_result
);

  localparam int LW  = (LEFT_MAX > 1) ? $clog2(LEFT_MAX) : 1;
  localparam int RW  = (RIGHT_MAX > 1) ? $clog2(RIGHT_MAX) : 1;
  localparam int LCW = $clog2(LEFT_MAX + 1);
  localparam int RCW = $clog2(RIGHT_MAX + 1);
  localparam int NW  = $clog2(MAX_RESULTS + 1);

  logic [COUNT_W-1:0]   left_count;
  logic [COUNT_W-1:0]   right_count;
  logic [RIGHT_MAX-1:0] adj [LEFT_MAX];
  logic [RW-1:0]        partner_left [LEFT_MAX];
  logic [LW-1:0]        partner_right [RIGHT_MAX];
  logic [LW-1:0]        via [RIGHT_MAX];
  logic [LEFT_MAX-1:0]  matched_left;
  logic [RIGHT_MAX-1:0] matched_right;
  logic [LEFT_MAX-1:0]  pend;
  logic [RIGHT_MAX-1:0] seen_right;
  logic [LEFT_MAX-1:0]  reached_left;
  logic [RIGHT_MAX-1:0] reached_right;
  logic [LCW-1:0]       start_idx;
  logic [LW-1:0]        start_reg;
  logic [RW-1:0]        cur;
  logic [LEFT_MAX-1:0]  cover_left;
  logic [RIGHT_MAX-1:0] cover_right;
  logic [COUNT_W-1:0]   lc;
  logic [COUNT_W-1:0]   rc;
  logic [NW-1:0]        count;

  logic [LCW-1:0]       eff_left;
  logic [RCW-1:0]       eff_right;
  logic [LEFT_MAX-1:0]  lmask;
  logic [RIGHT_MAX-1:0] rmask;
  logic [LW-1:0]        pop;
  logic [LEFT_MAX-1:0]  pop_hot;
  logic [RIGHT_MAX-1:0] aug_row;
  logic [RIGHT_MAX-1:0] free_row;
  logic [LEFT_MAX-1:0]  aug_new;
  logic [RIGHT_MAX-1:0] reach_row;
  logic [LEFT_MAX-1:0]  reach_new;
  logic [LW-1:0]        path_l;
  logic [LEFT_MAX-1:0]  cover_left_next;
  logic [RIGHT_MAX-1:0] cover_right_next;
  logic [LW-1:0]        low_l;
  logic [RW-1:0]        low_r;
  logic                 in_range;

  function automatic logic [LW-1:0] lowest_left(input logic [LEFT_MAX-1:0] x);
    logic [LW-1:0] r;
    r = '0;
    for (int i = LEFT_MAX - 1; i >= 0; i--) begin
      if (x[i]) r = LW'(i);
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] lowest_right(input logic [RIGHT_MAX-1:0] x);
    logic [RW-1:0] r;
    r = '0;
    for (int i = RIGHT_MAX - 1; i >= 0; i--) begin
      if (x[i]) r = RW'(i);
    end
    return r;
  endfunction

  always_comb begin
    eff_left  = (32'(left_count) > LEFT_MAX) ? LCW'(LEFT_MAX) : LCW'(left_count);
    eff_right = (32'(right_count) > RIGHT_MAX) ? RCW'(RIGHT_MAX) : RCW'(right_count);
    for (int i = 0; i < LEFT_MAX; i++) lmask[i] = (i < 32'(eff_left));
    for (int i = 0; i < RIGHT_MAX; i++) rmask[i] = (i < 32'(eff_right));
    in_range = (32'(left_vertex) < 32'(eff_left)) && (32'(right_vertex) < 32'(eff_right));

    pop = lowest_left(pend);
    for (int i = 0; i < LEFT_MAX; i++) pop_hot[i] = (pop == LW'(i));

    aug_row  = adj[pop] & rmask & ~seen_right;
    free_row = aug_row & ~matched_right;
    aug_new  = '0;
    for (int v = 0; v < RIGHT_MAX; v++) begin
      for (int i = 0; i < LEFT_MAX; i++) begin
        if (aug_row[v] && matched_right[v] && partner_right[v] == LW'(i)) aug_new[i] = 1'b1;
      end
    end

    reach_row = adj[pop] & rmask & ~reached_right;
    reach_new = '0;
    for (int v = 0; v < RIGHT_MAX; v++) begin
      for (int i = 0; i < LEFT_MAX; i++) begin
        if (reach_row[v] && matched_right[v] && partner_right[v] == LW'(i)) reach_new[i] = 1'b1;
      end
    end

    path_l = via[cur];

    low_l = lowest_left(cover_left);
    low_r = lowest_right(cover_right);
    cover_left_next  = cover_left;
    cover_right_next = cover_right;
    if (|cover_left) begin
      cover_left_next[low_l] = 1'b0;
    end else begin
      cover_right_next[low_r] = 1'b0;
    end

    status.more_starts = (32'(start_idx) < 32'(eff_left));
    status.pend_empty  = ~|pend;
    status.found_free  = |free_row;
    status.path_end    = (path_l == start_reg) || !matched_left[path_l];
    status.cover_empty = ~|cover_left && ~|cover_right;
    status.list_done   = (~|cover_left_next && ~|cover_right_next) ||
                         (32'(count) + 1 == MAX_RESULTS);

    left_cover_size  = lc;
    right_cover_size = rc;
    if (cmd.emit_list) begin
      if (|cover_left) begin
        item_kind    = KIND_LEFT;
        vertex_index = VERTEX_W'(low_l);
      end else begin
        item_kind    = KIND_RIGHT;
        vertex_index = VERTEX_W'(low_r);
      end
      last_result = ~|cover_left_next && ~|cover_right_next;
    end else begin
      item_kind    = KIND_SUMMARY;
      vertex_index = '0;
      last_result  = status.cover_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count    <= COUNT_W'(CFG_RESET);
      right_count   <= COUNT_W'(CFG_RESET);
      matched_left  <= '0;
      matched_right <= '0;
      for (int i = 0; i < LEFT_MAX; i++) adj[i] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LEFT_COUNT:  left_count  <= cfg_data;
          REG_RIGHT_COUNT: right_count <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.load && edge_present && in_range) begin
        adj[LW'(left_vertex)][RW'(right_vertex)] <= 1'b1;
      end

      if (cmd.match_init) begin
        matched_left  <= '0;
        matched_right <= '0;
        start_idx     <= '0;
      end

      if (cmd.aug_init) begin
        for (int i = 0; i < LEFT_MAX; i++) pend[i] <= (32'(start_idx) == i);
        seen_right <= '0;
        start_reg  <= LW'(start_idx);
      end

      if (cmd.aug_step) begin
        pend       <= (pend & ~pop_hot) | aug_new;
        seen_right <= seen_right | aug_row;
        for (int v = 0; v < RIGHT_MAX; v++) begin
          if (aug_row[v]) via[v] <= pop;
        end
        cur <= lowest_right(free_row);
      end

      if (cmd.aug_next) start_idx <= start_idx + 1'b1;

      if (cmd.path_step) begin
        partner_left[path_l] <= cur;
        partner_right[cur]   <= path_l;
        matched_left[path_l] <= 1'b1;
        matched_right[cur]   <= 1'b1;
        cur                  <= partner_left[path_l];
      end

      if (cmd.reach_init) begin
        reached_left  <= lmask & ~matched_left;
        pend          <= lmask & ~matched_left;
        reached_right <= '0;
      end

      if (cmd.reach_step) begin
        reached_right <= reached_right | reach_row;
        reached_left  <= reached_left | reach_new;
        pend          <= (pend & ~pop_hot) | (reach_new & ~reached_left);
      end

      if (cmd.out_init) begin
        cover_left  <= lmask & ~reached_left;
        cover_right <= reached_right;
        lc          <= COUNT_W'($countones(lmask & ~reached_left));
        rc          <= COUNT_W'($countones(reached_right));
        count       <= NW'(1);
        for (int i = 0; i < LEFT_MAX; i++) adj[i] <= '0;
      end

      if (cmd.emit_list) begin
        cover_left  <= cover_left_next;
        cover_right <= cover_right_next;
        count       <= count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/bmvc_ctrl.sv]
// ----------------------------------------------------------------------------
// bmvc_ctrl
// sequencer for load, matching, reachability and result phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmvc_ctrl
  import bmvc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    last_edge,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         result_valid
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_AUG_START  = 8'b0000_0010,
    S_AUG_SEARCH = 8'b0000_0100,
    S_AUG_PATH   = 8'b0000_1000,
    S_REACH_INIT = 8'b0001_0000,
    S_REACH      = 8'b0010_0000,
    S_OUT_SUM    = 8'b0100_0000,
    S_OUT_LIST   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_edge) begin
            cmd.match_init = 1'b1;
            state_next     = S_AUG_START;
          end
        end
      end
      S_AUG_START: begin
        if (status.more_starts) begin
          cmd.aug_init = 1'b1;
          state_next   = S_AUG_SEARCH;
        end else begin
          state_next = S_REACH_INIT;
        end
      end
      S_AUG_SEARCH: begin
        if (status.pend_empty) begin
          cmd.aug_next = 1'b1;
          state_next   = S_AUG_START;
        end else begin
          cmd.aug_step = 1'b1;
          if (status.found_free) state_next = S_AUG_PATH;
        end
      end
      S_AUG_PATH: begin
        cmd.path_step = 1'b1;
        if (status.path_end) begin
          cmd.aug_next = 1'b1;
          state_next   = S_AUG_START;
        end
      end
      S_REACH_INIT: begin
        cmd.reach_init = 1'b1;
        state_next     = S_REACH;
      end
      S_REACH: begin
        if (status.pend_empty) begin
          cmd.out_init = 1'b1;
          state_next   = S_OUT_SUM;
        end else begin
          cmd.reach_step = 1'b1;
        end
      end
      S_OUT_SUM: begin
        cmd.emit_sum = 1'b1;
        state_next   = status.cover_empty ? S_IDLE : S_OUT_LIST;
      end
      S_OUT_LIST: begin
        cmd.emit_list = 1'b1;
        if (status.list_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_OUT_SUM) || (state == S_OUT_LIST);

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bipartite minimum vertex cover block
// ----------------------------------------------------------------------------
// Edge sets are sent in bursts, first from a short stimulus table and then
// at random under a range of vertex counts. A local cover predictor tracks
// the adjacency matrix and, on each closing transaction without a typed
// expectation, queues the summary and the cover vertices. Every result strobe
// is checked against the oldest queued entry.
`timescale 1ns / 1ps

module tb_top;
  import bmvc_pkg::*;

  localparam int NV         = 16;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    item_kind_t         kind;
    logic [VERTEX_W-1:0] idx;
    logic [COUNT_W-1:0]  lcs;
    logic [COUNT_W-1:0]  rcs;
    logic                lst;
  } cover_item_t;

  typedef struct {
    int          l;
    int          r;
    bit          p;
    bit          last;
    bit          typed;
    cover_item_t exp;
  } edge_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [VERTEX_W-1:0] left_vertex;
  logic [VERTEX_W-1:0] right_vertex;
  logic                edge_present;
  logic                last_edge;
  logic                result_valid;
  logic [1:0]          item_kind;
  logic [VERTEX_W-1:0] vertex_index;
  logic [COUNT_W-1:0]  left_cover_size;
  logic [COUNT_W-1:0]  right_cover_size;
  logic                last_result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [COUNT_W-1:0]  cfg_data;

  bipartite_min_vertex_cover i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .left_vertex(left_vertex), .right_vertex(right_vertex),
    .edge_present(edge_present), .last_edge(last_edge),
    .result_valid(result_valid), .item_kind(item_kind),
    .vertex_index(vertex_index), .left_cover_size(left_cover_size),
    .right_cover_size(right_cover_size), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cover_item_t          cover_q[$];
  logic [NV-1:0]        adj_rows[NV];
  logic [COUNT_W-1:0]   left_cnt;
  logic [COUNT_W-1:0]   right_cnt;
  int                   errors;
  int                   idle_cycles;
  int                   items_sent;
  int                   burst_left;
  bit                   gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_count(logic [COUNT_W-1:0] c);
    return (c > NV) ? NV : int'(c);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // maximum matching by augmenting search, then residual reachability
  task automatic predict_cover();
    int nl, nr, pl[NV], pr[NV], via[NV], q[NV+1];
    int head, tail, found, a, v, nxt, lc, rc, total, k;
    logic [NV-1:0] visr, rl, rr;
    cover_item_t it;
    nl = eff_count(left_cnt);
    nr = eff_count(right_cnt);
    for (int i = 0; i < NV; i++) begin
      pl[i] = -1;
      pr[i] = -1;
    end
    for (int u = 0; u < nl; u++) begin
      visr = '0;
      q[0] = u;
      head = 0;
      tail = 1;
      found = -1;
      while (head < tail && found < 0) begin
        a = q[head];
        head++;
        for (int w = 0; w < nr && found < 0; w++) begin
          if (adj_rows[a][w] && !visr[w]) begin
            visr[w] = 1'b1;
            via[w] = a;
            if (pr[w] < 0) found = w;
            else begin
              q[tail] = pr[w];
              tail++;
            end
          end
        end
      end
      if (found >= 0) begin
        v = found;
        forever begin
          a = via[v];
          nxt = pl[a];
          pl[a] = v;
          pr[v] = a;
          if (a == u) break;
          v = nxt;
        end
      end
    end
    rl = '0;
    rr = '0;
    for (int u = 0; u < nl; u++) if (pl[u] < 0) rl[u] = 1'b1;
    repeat (NV + 1) begin
      for (int u = 0; u < nl; u++) begin
        if (rl[u]) begin
          for (int w = 0; w < nr; w++) begin
            if (adj_rows[u][w]) begin
              rr[w] = 1'b1;
              if (pr[w] >= 0) rl[pr[w]] = 1'b1;
            end
          end
        end
      end
    end
    lc = 0;
    rc = 0;
    for (int u = 0; u < nl; u++) if (!rl[u]) lc++;
    for (int w = 0; w < nr; w++) if (rr[w]) rc++;
    total = 1 + lc + rc;
    k = 1;
    it = '{KIND_SUMMARY, '0, lc[COUNT_W-1:0], rc[COUNT_W-1:0], total == 1};
    cover_q.push_back(it);
    for (int u = 0; u < nl; u++) begin
      if (!rl[u]) begin
        k++;
        it = '{KIND_LEFT, u[VERTEX_W-1:0], lc[COUNT_W-1:0], rc[COUNT_W-1:0], k == total};
        cover_q.push_back(it);
      end
    end
    for (int w = 0; w < nr; w++) begin
      if (rr[w]) begin
        k++;
        it = '{KIND_RIGHT, w[VERTEX_W-1:0], lc[COUNT_W-1:0], rc[COUNT_W-1:0], k == total};
        cover_q.push_back(it);
      end
    end
    for (int i = 0; i < NV; i++) adj_rows[i] = '0;
  endtask

  // one edge transaction; called at a falling edge, returns at one
  task automatic send_edge(int l, int r, bit p, bit last, bit typed, cover_item_t exp);
    if (burst_left == 0) begin
      if (gaps_on) begin
        start = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    start = 1'b1;
    left_vertex = l[VERTEX_W-1:0];
    right_vertex = r[VERTEX_W-1:0];
    edge_present = p;
    last_edge = last;
    do @(posedge clk); while (busy);
    if (p && l < eff_count(left_cnt) && r < eff_count(right_cnt)) adj_rows[l][r] = 1'b1;
    if (last) begin
      if (typed) begin
        cover_q.push_back(exp);
        for (int i = 0; i < NV; i++) adj_rows[i] = '0;
      end else begin
        predict_cover();
      end
    end
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [COUNT_W-1:0] val);
    start = 1'b0;
    while (cover_q.size() != 0 || busy) @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LEFT_COUNT) left_cnt = val;
    else right_cnt = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_counts(int lv, int rv);
    write_reg(REG_LEFT_COUNT, lv[COUNT_W-1:0]);
    write_reg(REG_RIGHT_COUNT, rv[COUNT_W-1:0]);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) begin
        if (cover_q.size() == 0) begin
          $display("unexpected result transaction at %0t", $time);
          errors++;
        end else begin
          cover_item_t e;
          e = cover_q.pop_front();
          if (item_kind != e.kind) report_mismatch("item_kind", item_kind, e.kind);
          if (vertex_index != e.idx) report_mismatch("vertex_index", vertex_index, e.idx);
          if (left_cover_size != e.lcs)
            report_mismatch("left_cover_size", left_cover_size, e.lcs);
          if (right_cover_size != e.rcs)
            report_mismatch("right_cover_size", right_cover_size, e.rcs);
          if (last_result != e.lst) report_mismatch("last_result", last_result, e.lst);
        end
      end
      if (result_valid || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  edge_row_t dir_rows[] = '{
    '{0, 0, 0, 1, 1, '{KIND_SUMMARY, 4'd0, 5'd0, 5'd0, 1'b1}},
    '{0, 0, 1, 0, 0, '0}, '{0, 1, 1, 0, 0, '0}, '{1, 0, 1, 0, 0, '0},
    '{1, 1, 1, 1, 0, '0},
    '{15, 15, 1, 1, 0, '0},
    '{5, 5, 0, 0, 0, '0}, '{3, 3, 1, 1, 0, '0},
    '{2, 0, 1, 0, 0, '0}, '{2, 1, 1, 0, 0, '0}, '{2, 2, 1, 0, 0, '0},
    '{2, 3, 1, 0, 0, '0}, '{2, 4, 1, 1, 0, '0},
    '{0, 15, 1, 0, 0, '0}, '{15, 0, 1, 0, 0, '0}, '{7, 8, 1, 0, 0, '0},
    '{8, 7, 1, 0, 0, '0}, '{7, 7, 1, 1, 0, '0}
  };

  initial begin
    int cfg_l[] = '{0, 31, 1, 16, 17, 8, 16, 3};
    int cfg_r[] = '{0, 31, 16, 1, 20, 5, 16, 12};
    int ph, sz, nl, nr, roll;
    rst = 1'b1;
    start = 1'b0;
    left_vertex = '0;
    right_vertex = '0;
    edge_present = 1'b0;
    last_edge = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_LEFT_COUNT;
    cfg_data = '0;
    errors = 0;
    idle_cycles = 0;
    items_sent = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    left_cnt = CFG_RESET;
    right_cnt = CFG_RESET;
    for (int i = 0; i < NV; i++) adj_rows[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[i])
      send_edge(dir_rows[i].l, dir_rows[i].r, dir_rows[i].p, dir_rows[i].last,
                dir_rows[i].typed, dir_rows[i].exp);

    ph = 0;
    while (items_sent < 255) begin
      if (ph < cfg_l.size()) set_counts(cfg_l[ph], cfg_r[ph]);
      else set_counts($urandom_range(0, 31), $urandom_range(0, 31));
      ph++;
      gaps_on = $urandom_range(0, 3) != 0;
      nl = eff_count(left_cnt);
      nr = eff_count(right_cnt);
      repeat (3) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 12);
        for (int e = 0; e <= sz; e++) begin
          roll = $urandom_range(0, 9);
          if (roll == 0)
            send_edge($urandom_range(0, 15), $urandom_range(0, 15), 0, e == sz, 0, '0);
          else if (roll == 1 || nl == 0 || nr == 0)
            send_edge($urandom_range(0, 15), $urandom_range(0, 15), 1, e == sz, 0, '0);
          else
            send_edge($urandom_range(0, nl - 1), $urandom_range(0, nr - 1), 1, e == sz, 0, '0);
        end
      end
    end
    start = 1'b0;
    while (cover_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bmvc_pkg.sv
src/bmvc_datapath.sv
src/bmvc_ctrl.sv
src/bipartite_min_vertex_cover.sv
tb/tb_top.sv
